// ===== hw/rtl/lbp_pkg.sv =====
// Shared types and constants of the 3x3 local binary pattern block.
`default_nettype none

package lbp_pkg;

	localparam int PIX_W        = 8;
	localparam int FRAME_COLS_W = 11;
	localparam int FRAME_ROWS_W = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 16;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

	localparam logic [FRAME_COLS_W-1:0] FRAME_COLS_RESET = FRAME_COLS_W'(640);
	localparam logic [FRAME_ROWS_W-1:0] FRAME_ROWS_RESET = FRAME_ROWS_W'(480);

	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = CFG_IDX_W'(1);

	typedef enum logic [0:0] {
		OP_PIXEL = 1'b0,
		OP_FLUSH = 1'b1
	} lbp_op_t;

	// One pending result: the eight neighbours in code bit order and the centre.
	typedef struct packed {
		logic [7:0][PIX_W-1:0] nb;
		logic [PIX_W-1:0]      centre;
		logic                  interior;
		logic                  eof;
	} lbp_win_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lbp_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none

module lbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_front.sv =====
// Front end: configuration, frame counters, item classification, line buffers, window.
`default_nettype none

module lbp_front import lbp_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push,
	output logic                         full,
	input  wire logic                    opcode,
	input  wire logic [PIX_W-1:0]        pixel_in,
	input  wire logic                    cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]    cfg_idx,
	input  wire logic [CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic [QCNT_W-1:0]       q_count,
	output logic                         q_push,
	output lbp_win_t                     q_data
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int CNT_W = $clog2(MAX_WIDTH + 1);
	localparam int LAG_W = $clog2(MAX_WIDTH + 2);
	localparam int LB_W  = 2 * PIX_W;

	logic [FRAME_COLS_W-1:0] frame_cols_q;
	logic [FRAME_ROWS_W-1:0] frame_rows_q;

	logic [COL_W-1:0]        col_q;
	logic [FRAME_ROWS_W-1:0] in_row_q;
	logic [COL_W-1:0]        out_col_q;
	logic [FRAME_ROWS_W-1:0] out_row_q;
	logic [LAG_W-1:0]        lag_q;
	logic                    started_q;

	logic [CNT_W-1:0]        cols_eff;
	logic [FRAME_ROWS_W-1:0] rows_eff;

	logic accept, input_phase, ignore, counted, lag_done, produce;
	logic col_wrap, out_col_wrap, interior, eof, cfg_hit;

	logic                 v_s1, prod_s1, int_s1, eof_s1, byp_s1;
	logic [PIX_W-1:0]     pix_s1;
	logic [COL_W-1:0]     addr_s1;
	logic [LB_W-1:0]      byp_data_s1;
	logic [LB_W-1:0]      ram_rdata;
	logic [LB_W-1:0]      lb_col;
	logic [2:0][PIX_W-1:0] cur_col;
	logic [2:0][PIX_W-1:0] prev1_q;
	logic [2:0][PIX_W-1:0] prev2_q;

	always_comb begin
		if (frame_cols_q == '0) begin
			cols_eff = CNT_W'(1);
		end else if (32'(frame_cols_q) > MAX_WIDTH) begin
			cols_eff = CNT_W'(MAX_WIDTH);
		end else begin
			cols_eff = CNT_W'(frame_cols_q);
		end
	end

	assign rows_eff = (frame_rows_q == '0) ? FRAME_ROWS_W'(1) : frame_rows_q;

	// The queue has to hold every item that may still be in the pipeline stage.
	assign full   = (32'(q_count) + 32'(v_s1)) >= QUEUE_DEPTH;
	assign accept = push && !full;

	assign input_phase = in_row_q < rows_eff;
	assign ignore      = input_phase && (lbp_op_t'(opcode) == OP_FLUSH);
	assign counted     = accept && !ignore;
	assign lag_done    = started_q || (32'(lag_q) >= 32'(cols_eff) + 32'd1);
	assign produce     = counted && lag_done;

	assign col_wrap     = (32'(col_q) + 32'd1) >= 32'(cols_eff);
	assign out_col_wrap = (32'(out_col_q) + 32'd1) >= 32'(cols_eff);

	assign interior = (out_row_q != '0) && ((32'(out_row_q) + 32'd1) < 32'(rows_eff)) &&
	                  (out_col_q != '0) && ((32'(out_col_q) + 32'd1) < 32'(cols_eff));
	assign eof      = ((32'(out_row_q) + 32'd1) == 32'(rows_eff)) &&
	                  ((32'(out_col_q) + 32'd1) == 32'(cols_eff));

	assign cfg_hit = cfg_wen && ((cfg_idx == CFG_FRAME_COLS) || (cfg_idx == CFG_FRAME_ROWS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cols_q <= FRAME_COLS_RESET;
			frame_rows_q <= FRAME_ROWS_RESET;
			col_q        <= '0;
			in_row_q     <= '0;
			out_col_q    <= '0;
			out_row_q    <= '0;
			lag_q        <= '0;
			started_q    <= 1'b0;
		end else if (cfg_hit) begin
			if (cfg_idx == CFG_FRAME_COLS) begin
				frame_cols_q <= cfg_wdata[FRAME_COLS_W-1:0];
			end else begin
				frame_rows_q <= cfg_wdata[FRAME_ROWS_W-1:0];
			end
			col_q     <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lag_q     <= '0;
			started_q <= 1'b0;
		end else if (counted) begin
			if (produce && eof) begin
				col_q     <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
				lag_q     <= '0;
				started_q <= 1'b0;
			end else begin
				// The column keeps running through the drain so the line buffers stay aligned.
				col_q <= col_wrap ? '0 : col_q + COL_W'(1);
				if (input_phase && col_wrap) begin
					in_row_q <= in_row_q + FRAME_ROWS_W'(1);
				end
				if (!lag_done) begin
					lag_q <= lag_q + LAG_W'(1);
				end else begin
					started_q <= 1'b1;
				end
				if (produce) begin
					if (out_col_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + FRAME_ROWS_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

	// Each line buffer entry holds {two rows up, one row up} for its column.
	lbp_ram #(
		.WIDTH(LB_W),
		.DEPTH(MAX_WIDTH)
	) u_line_ram (
		.clk  (clk),
		.we   (v_s1),
		.waddr(addr_s1),
		.wdata({lb_col[PIX_W-1:0], pix_s1}),
		.re   (counted),
		.raddr(col_q),
		.rdata(ram_rdata)
	);

	// A one-column frame reads the entry that is being written in the same cycle.
	assign lb_col = byp_s1 ? byp_data_s1 : ram_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			prod_s1 <= 1'b0;
			byp_s1  <= 1'b0;
		end else begin
			v_s1    <= counted;
			prod_s1 <= produce;
			byp_s1  <= counted && v_s1 && (col_q == addr_s1);
		end
	end

	always_ff @(posedge clk) begin
		byp_data_s1 <= {lb_col[PIX_W-1:0], pix_s1};
		if (counted) begin
			pix_s1  <= pixel_in;
			addr_s1 <= col_q;
			int_s1  <= interior;
			eof_s1  <= eof;
		end
	end

	assign cur_col[0] = lb_col[LB_W-1:PIX_W];
	assign cur_col[1] = lb_col[PIX_W-1:0];
	assign cur_col[2] = pix_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev1_q <= '0;
			prev2_q <= '0;
		end else if (v_s1) begin
			prev1_q <= cur_col;
			prev2_q <= prev1_q;
		end
	end

	// The result's centre column is the one shifted in by the previous item.
	always_comb begin
		q_data.nb[0]    = prev2_q[0];
		q_data.nb[1]    = prev1_q[0];
		q_data.nb[2]    = cur_col[0];
		q_data.nb[3]    = prev2_q[1];
		q_data.nb[4]    = cur_col[1];
		q_data.nb[5]    = prev2_q[2];
		q_data.nb[6]    = prev1_q[2];
		q_data.nb[7]    = cur_col[2];
		q_data.centre   = prev1_q[1];
		q_data.interior = int_s1;
		q_data.eof      = eof_s1;
	end

	assign q_push = v_s1 && prod_s1;

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_queue.sv =====
// Short queue of pending windows between the front end and the back end.
`default_nettype none

module lbp_queue import lbp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire lbp_win_t          din,
	input  wire logic              deq,
	output lbp_win_t               dout,
	output logic [QCNT_W-1:0]      count
);

	lbp_win_t            slots [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_deq;

	assign do_deq = deq && (count_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_deq) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			count_q <= count_q + QCNT_W'(push) - QCNT_W'(do_deq);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots[wr_ptr_q] <= din;
		end
	end

	assign dout  = slots[rd_ptr_q];
	assign count = count_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_back.sv =====
// Back end: neighbour compares and the result register.
`default_nettype none

module lbp_back import lbp_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lbp_win_t          head,
	input  wire logic              head_valid,
	output logic                   deq,
	output logic                   empty,
	input  wire logic              pop,
	output logic [PIX_W-1:0]       pixel_out,
	output logic                   end_of_frame
);

	logic             out_v_q;
	logic [PIX_W-1:0] pixel_q;
	logic             eof_q;
	logic [7:0]       code;

	always_comb begin
		for (int n = 0; n < 8; n++) begin
			code[n] = head.nb[n] >= head.centre;
		end
	end

	assign deq = head_valid && (!out_v_q || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (deq) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (deq) begin
			pixel_q <= head.interior ? code : head.centre;
			eof_q   <= head.eof;
		end
	end

	assign empty        = !out_v_q;
	assign pixel_out    = pixel_q;
	assign end_of_frame = eof_q;

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_3x3_pixel_stream.sv =====
// Top level of the 3x3 local binary pattern pixel stream block.
//
//  channel   direction  handshake                 payload
//  input     in         push / full               opcode, pixel_in
//  result    out        empty / pop               pixel_out, end_of_frame
//  config    in         cfg_wen (no wait)         cfg_idx, cfg_wdata
//
// One item is accepted per clock while full is low; a result, caused by the item
// frame_cols+1 counted items after its pixel, passes the pipeline stage and queue into
// the result register. The line buffer RAM is read and written once per item, which
// sets the one-item rate. Reset clears counters, valid flags and window registers and
// resets the frame size; the line buffer is not cleared. full rises when the queued
// windows and the item in the pipeline stage together reach the four queue entries.
`default_nettype none

module lbp_3x3_pixel_stream import lbp_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic                  opcode,
	input  wire logic [PIX_W-1:0]      pixel_in,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [PIX_W-1:0]           pixel_out,
	output logic                       end_of_frame,
	input  wire logic                  cfg_wen,
	input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	logic              q_push;
	lbp_win_t          q_din;
	lbp_win_t          q_head;
	logic              q_deq;
	logic [QCNT_W-1:0] q_count;

	lbp_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.opcode   (opcode),
		.pixel_in (pixel_in),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.q_count  (q_count),
		.q_push   (q_push),
		.q_data   (q_din)
	);

	lbp_queue u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.din   (q_din),
		.deq   (q_deq),
		.dout  (q_head),
		.count (q_count)
	);

	lbp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.head_valid  (q_count != '0),
		.deq         (q_deq),
		.empty       (empty),
		.pop         (pop),
		.pixel_out   (pixel_out),
		.end_of_frame(end_of_frame)
	);

endmodule

`default_nettype wire
